// ===== rtl/bss_pkg.sv =====
package bss_pkg;

  // Command codes
  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_REMOVE = 3'd1;
  localparam logic [2:0] CMD_QUERY  = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_PICK   = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOCHANGE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BAD      = 2'd3;

  // One result beat
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  count;
    logic [31:0] value;
  } result_t;

endpackage

// ===== rtl/bss_out_stage.sv =====
module bss_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  bss_pkg::result_t  res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic [7:0]        count,
  output logic [31:0]       value
);
  import bss_pkg::*;

  // The slot can take a new result when empty or being drained this cycle
  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      status <= res.status;
      count  <= res.count;
      value  <= res.value;
    end
  end

endmodule

// ===== rtl/bounded_set_store.sv =====
// Channel  Handshake             Payload
// in       in_valid / in_ready   cmd[2:0], element[31:0], pick_index[6:0]
// out      out_valid / out_ready status[1:0], count[7:0], value[31:0]
//
// One command at a time; entries sit in a RAM with a registered read port.
// A lookup reads one entry per cycle; a remove that hits then compacts the entries
// after the hit. Clear and a full insert go straight to the result; pick reads its entry first.
// rst is synchronous; it empties the set (entry contents are left as they are).
// A command is taken while a result still waits; it stalls at its own result until that drains.
module bounded_set_store #(
  parameter int DEPTH      = 128,
  parameter int ELEM_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [31:0] element,
  input  logic [6:0]  pick_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  count,
  output logic [31:0] value
);
  import bss_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 7) ? CW : 7;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_PICK  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]            state;
  logic [CW-1:0]         fill_count;
  logic [2:0]            op;
  logic [ELEM_WIDTH-1:0] key;
  logic [CW-1:0]         ptr;
  logic                  pend;
  logic [CW-1:0]         pend_idx;
  logic [1:0]            res_status;
  logic [31:0]           res_value;

  logic [ELEM_WIDTH-1:0] mem [DEPTH];
  logic [ELEM_WIDTH-1:0] rd_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [ELEM_WIDTH-1:0] wr_data;

  logic                  issue;
  logic                  match;
  logic                  walk_done;
  logic                  pick_bad;
  logic                  load;
  logic                  free;
  result_t               res;

  assign in_ready  = (state == S_IDLE);
  assign issue     = (ptr < fill_count);
  assign match     = pend && (rd_data == key);
  assign walk_done = !issue && !pend;
  assign pick_bad  = (CMPW'(pick_index) >= CMPW'(fill_count));
  assign load      = (state == S_RESP) && free;

  // Memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = AW'(pend_idx - 1'b1);
    wr_data = rd_data;
    unique case (state)
      S_IDLE: begin
        rd_en   = in_valid && (cmd == CMD_PICK);
        rd_addr = AW'(pick_index);
      end
      S_SCAN: begin
        rd_en = issue;
        // append on a miss
        if (!match && walk_done && op == CMD_INSERT) begin
          wr_en   = 1'b1;
          wr_addr = AW'(fill_count);
          wr_data = key;
        end
      end
      S_SHIFT: begin
        rd_en = issue;
        wr_en = pend;
      end
      default: begin
      end
    endcase
  end

  // Entry RAM
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      pend       <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op        <= cmd;
            key       <= ELEM_WIDTH'(element);
            ptr       <= '0;
            pend      <= 1'b0;
            res_value <= '0;
            unique case (cmd)
              CMD_INSERT: begin
                if (fill_count == CW'(DEPTH)) begin
                  res_status <= ST_FULL;
                  state      <= S_RESP;
                end else begin
                  state <= S_SCAN;
                end
              end
              CMD_REMOVE, CMD_QUERY: state <= S_SCAN;
              CMD_CLEAR: begin
                fill_count <= '0;
                res_status <= ST_OK;
                state      <= S_RESP;
              end
              CMD_PICK: begin
                if (pick_bad) begin
                  res_status <= ST_BAD;
                  state      <= S_RESP;
                end else begin
                  state <= S_PICK;
                end
              end
              default: begin
                res_status <= ST_NOCHANGE;
                state      <= S_RESP;
              end
            endcase
          end
        end

        // Linear search, one read issued and one compare per cycle
        S_SCAN: begin
          if (match && op == CMD_REMOVE) begin
            // remove: start compaction from the entry after the hit
            ptr   <= pend_idx + 1'b1;
            pend  <= 1'b0;
            state <= S_SHIFT;
          end else begin
            pend     <= issue;
            pend_idx <= ptr;
            if (issue) begin
              ptr <= ptr + 1'b1;
            end
            if (match) begin
              // insert of a held element changes nothing; query finds it
              res_status <= (op == CMD_INSERT) ? ST_NOCHANGE : ST_OK;
              state      <= S_RESP;
            end else if (walk_done) begin
              if (op == CMD_INSERT) begin
                fill_count <= fill_count + 1'b1;
                res_status <= ST_OK;
              end else begin
                res_status <= ST_NOCHANGE;
              end
              state <= S_RESP;
            end
          end
        end

        // Compaction: read entry j+1, write it to j in the following cycle
        S_SHIFT: begin
          pend     <= issue;
          pend_idx <= ptr;
          if (issue) begin
            ptr <= ptr + 1'b1;
          end
          if (walk_done) begin
            fill_count <= fill_count - 1'b1;
            res_status <= ST_OK;
            state      <= S_RESP;
          end
        end

        S_PICK: begin
          res_value  <= 32'(rd_data);
          res_status <= ST_OK;
          state      <= S_RESP;
        end

        S_RESP: begin
          if (free) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.status = res_status;
  assign res.count  = 8'(fill_count);
  assign res.value  = res_value;

  bss_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .res       (res),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .count     (count),
    .value     (value)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(DEPTH))
    else $error("fill count beyond depth");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while busy");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    fill_count != $past(fill_count) |->
      (fill_count == '0 || fill_count == CW'($past(fill_count) + 1'b1) ||
       fill_count == CW'($past(fill_count) - 1'b1)))
    else $error("fill count jumped");

  a_shift_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> fill_count != '0)
    else $error("compaction on empty set");
`endif

endmodule

// ===== bench/tb_bounded_set_store.sv =====
module tb_bounded_set_store;
  import bss_pkg::*;

  localparam int SET_DEPTH      = 128;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  // Command codes the block ignores
  localparam logic [2:0] CMD_RSVD_LO = 3'd5;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] elem;
    logic [6:0]  idx;
    bit          has_ans;
    result_t     ans;
  } cmd_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  cmd = CMD_QUERY;
  logic [31:0] element = '0;
  logic [6:0]  pick_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [7:0]  count;
  logic [31:0] value;

  // Shadow copy of the set
  logic [31:0] set_mem [SET_DEPTH];
  int          set_count = 0;

  cmd_row_t    directed_cmds[$];
  cmd_row_t    offered_cmds[$];
  result_t     awaited_results[$];

  int          fail_count = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_req = 1'b0;

  always #4 clk = ~clk;

  bounded_set_store #(
    .DEPTH      (SET_DEPTH),
    .ELEM_WIDTH (32)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .element    (element),
    .pick_index (pick_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .count      (count),
    .value      (value)
  );

  // Position of an element among the held entries, set_count if absent
  function automatic int find_slot(input logic [31:0] elem);
    for (int i = 0; i < set_count; i++) begin
      if (set_mem[i] == elem) return i;
    end
    return set_count;
  endfunction

  // Applies one command to the shadow set and returns the answer it gives
  function automatic result_t set_apply(input logic [2:0] op, input logic [31:0] elem,
                                        input logic [6:0] idx);
    result_t r;
    int      pos;
    r.status = ST_NOCHANGE;
    r.value  = '0;
    pos      = find_slot(elem);
    case (op)
      CMD_INSERT: begin
        // full check wins over the presence check
        if (set_count >= SET_DEPTH) begin
          r.status = ST_FULL;
        end else if (pos < set_count) begin
          r.status = ST_NOCHANGE;
        end else begin
          set_mem[set_count] = elem;
          set_count++;
          r.status = ST_OK;
        end
      end
      CMD_REMOVE: begin
        if (pos < set_count) begin
          for (int j = pos; j < set_count - 1; j++) set_mem[j] = set_mem[j + 1];
          set_count--;
          r.status = ST_OK;
        end
      end
      CMD_QUERY: r.status = (pos < set_count) ? ST_OK : ST_NOCHANGE;
      CMD_CLEAR: begin
        set_count = 0;
        r.status  = ST_OK;
      end
      CMD_PICK: begin
        if (idx >= set_count) begin
          r.status = ST_BAD;
        end else begin
          r.value  = set_mem[idx];
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    r.count = set_count[7:0];
    return r;
  endfunction

  function automatic void add_row(input logic [2:0] op, input logic [31:0] elem,
                                  input logic [6:0] idx, input bit has_ans,
                                  input logic [1:0] st, input logic [7:0] cnt,
                                  input logic [31:0] val);
    cmd_row_t row;
    row.op      = op;
    row.elem    = elem;
    row.idx     = idx;
    row.has_ans = has_ans;
    row.ans     = '{status: st, count: cnt, value: val};
    directed_cmds.push_back(row);
  endfunction

  // Element values biased towards a small pool and the extremes
  function automatic logic [31:0] rand_elem();
    int r;
    r = $urandom_range(99);
    if (r < 30) return $urandom_range(15);
    if (r < 35) return '0;
    if (r < 40) return '1;
    return $urandom;
  endfunction

  function automatic logic [31:0] present_elem();
    return set_mem[$urandom_range(set_count - 1)];
  endfunction

  function automatic logic [31:0] fresh_elem();
    logic [31:0] e;
    e = $urandom;
    while (find_slot(e) < set_count) e = $urandom;
    return e;
  endfunction

  // Offers one beat; entered and left just after a falling edge
  task automatic issue_row(input cmd_row_t row);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    offered_cmds.push_back(row);
    in_valid   <= 1'b1;
    cmd        <= row.op;
    element    <= row.elem;
    pick_index <= row.idx;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic issue_cmd(input logic [2:0] op, input logic [31:0] elem,
                           input logic [6:0] idx);
    cmd_row_t row;
    row.op      = op;
    row.elem    = elem;
    row.idx     = idx;
    row.has_ans = 1'b0;
    row.ans     = '0;
    issue_row(row);
  endtask

  // Random mix of all commands, leaning on elements already held
  task automatic run_mixed(input int n);
    int          r;
    logic [31:0] e;
    logic [6:0]  ix;
    repeat (n) begin
      r  = $urandom_range(99);
      e  = rand_elem();
      ix = 7'($urandom_range(127));
      if (r < 35) begin
        if (set_count > 0 && $urandom_range(4) == 0) e = present_elem();
        issue_cmd(CMD_INSERT, e, ix);
      end else if (r < 55) begin
        if (set_count > 0 && $urandom_range(99) < 65) e = present_elem();
        issue_cmd(CMD_REMOVE, e, ix);
      end else if (r < 72) begin
        if (set_count > 0 && $urandom_range(1) == 0) e = present_elem();
        issue_cmd(CMD_QUERY, e, ix);
      end else if (r < 92) begin
        if (set_count > 0 && $urandom_range(3) != 0) ix = 7'($urandom_range(set_count - 1));
        issue_cmd(CMD_PICK, e, ix);
      end else if (r < 95) begin
        issue_cmd(CMD_CLEAR, e, ix);
      end else begin
        issue_cmd(3'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO)), e, ix);
      end
    end
  endtask

  // Fills the set to capacity, then works at the full boundary
  task automatic fill_to_capacity();
    while (set_count < SET_DEPTH) begin
      if (set_count > 0 && $urandom_range(9) == 0)
        issue_cmd(CMD_INSERT, present_elem(), 7'($urandom_range(127)));
      else
        issue_cmd(CMD_INSERT, fresh_elem(), 7'($urandom_range(127)));
    end
    issue_cmd(CMD_INSERT, present_elem(), 7'($urandom_range(127)));
    issue_cmd(CMD_INSERT, fresh_elem(), 7'($urandom_range(127)));
    issue_cmd(CMD_PICK, $urandom, 7'd127);
    issue_cmd(CMD_QUERY, present_elem(), 7'($urandom_range(127)));
    // head removal shifts every later entry
    issue_cmd(CMD_REMOVE, set_mem[0], 7'($urandom_range(127)));
    issue_cmd(CMD_INSERT, fresh_elem(), 7'($urandom_range(127)));
    issue_cmd(CMD_REMOVE, set_mem[SET_DEPTH - 1], 7'($urandom_range(127)));
    issue_cmd(CMD_PICK, $urandom, 7'd127);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Prediction on each accepted command, checking on each result beat
  always @(posedge clk) begin
    cmd_row_t row;
    result_t  want;
    result_t  got;
    if (!rst) begin
      if (in_valid && in_ready) begin
        row  = offered_cmds.pop_front();
        want = set_apply(row.op, row.elem, row.idx);
        awaited_results.push_back(row.has_ans ? row.ans : want);
      end
      if (out_valid && out_ready) begin
        got = '{status: status, count: count, value: value};
        if (awaited_results.size() == 0) begin
          $display("%0t: result beat with none expected: status %0d count %0d value %h",
                   $time, got.status, got.count, got.value);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, got.status);
            fail_count++;
          end
          if (got.count !== want.count) begin
            $display("%0t: count mismatch: expected %0d actual %0d",
                     $time, want.count, got.count);
            fail_count++;
          end
          if (got.value !== want.value) begin
            $display("%0t: value mismatch: expected %h actual %h",
                     $time, want.value, got.value);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
      $display("bounded_set_store verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed: empty set, extremes, duplicates, shifts, ignored codes, clear
    add_row(CMD_PICK,    32'h0,        7'd0,   1'b1, ST_BAD,      8'd0, 32'h0);
    add_row(CMD_QUERY,   32'h0,        7'd0,   1'b1, ST_NOCHANGE, 8'd0, 32'h0);
    add_row(CMD_REMOVE,  32'h5,        7'd0,   1'b1, ST_NOCHANGE, 8'd0, 32'h0);
    add_row(CMD_INSERT,  32'h0,        7'd0,   1'b1, ST_OK,       8'd1, 32'h0);
    add_row(CMD_INSERT,  32'hFFFF_FFFF, 7'd127, 1'b1, ST_OK,      8'd2, 32'h0);
    add_row(CMD_INSERT,  32'h0,        7'd0,   1'b1, ST_NOCHANGE, 8'd2, 32'h0);
    add_row(CMD_QUERY,   32'hFFFF_FFFF, 7'd0,  1'b1, ST_OK,       8'd2, 32'h0);
    add_row(CMD_PICK,    32'h1234,     7'd1,   1'b1, ST_OK,       8'd2, 32'hFFFF_FFFF);
    add_row(CMD_PICK,    32'h0,        7'd2,   1'b1, ST_BAD,      8'd2, 32'h0);
    add_row(CMD_PICK,    32'h0,        7'd127, 1'b1, ST_BAD,      8'd2, 32'h0);
    add_row(CMD_INSERT,  32'hA5A5_A5A5, 7'd0,  1'b0, ST_OK,       8'd0, 32'h0);
    add_row(CMD_INSERT,  32'h5A5A_5A5A, 7'd0,  1'b0, ST_OK,       8'd0, 32'h0);
    add_row(CMD_REMOVE,  32'h0,        7'd0,   1'b0, ST_OK,       8'd0, 32'h0);
    add_row(CMD_PICK,    32'h0,        7'd0,   1'b0, ST_OK,       8'd0, 32'h0);
    add_row(CMD_PICK,    32'h0,        7'd2,   1'b0, ST_OK,       8'd0, 32'h0);
    add_row(CMD_REMOVE,  32'h5A5A_5A5A, 7'd0,  1'b0, ST_OK,       8'd0, 32'h0);
    add_row(CMD_REMOVE,  32'h5A5A_5A5A, 7'd0,  1'b0, ST_OK,       8'd0, 32'h0);
    add_row(CMD_RSVD_LO, 32'hFFFF_FFFF, 7'd127, 1'b1, ST_NOCHANGE, 8'd2, 32'h0);
    add_row(CMD_RSVD_LO + 3'd1, 32'h0, 7'd0,   1'b1, ST_NOCHANGE, 8'd2, 32'h0);
    add_row(CMD_RSVD_HI, 32'hA5A5_A5A5, 7'd1,  1'b1, ST_NOCHANGE, 8'd2, 32'h0);
    add_row(CMD_CLEAR,   32'h0,        7'd0,   1'b1, ST_OK,       8'd0, 32'h0);
    add_row(CMD_PICK,    32'h0,        7'd0,   1'b1, ST_BAD,      8'd0, 32'h0);
    add_row(CMD_INSERT,  32'hFFFF_FFFF, 7'd0,  1'b1, ST_OK,       8'd1, 32'h0);
    foreach (directed_cmds[k]) issue_row(directed_cmds[k]);

    // Random phases with different idling on each side
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_req       = 1'b1;
        end
        1: begin
          send_idle_pct  = 62;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 62;
        end
        default: begin
          send_idle_pct  = 15;
          recv_stall_pct = 15;
        end
      endcase
      run_mixed(90);
      fill_to_capacity();
      run_mixed(90);
    end

    // Drain outstanding results
    in_valid      <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (awaited_results.size() != 0 || offered_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("bounded_set_store verification clean");
    end else begin
      $display("bounded_set_store verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bss_pkg.sv
rtl/bss_out_stage.sv
rtl/bounded_set_store.sv
bench/tb_bounded_set_store.sv
